[rtl/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES       = 8;
    localparam int CLS_W             = 3;
    localparam int BLK_W             = 6;
    localparam int DEPTH_W           = 7;
    localparam int MARK_W            = 8;
    localparam int TOTAL_BLOCKS      = 190;
    localparam int MAX_PER_CLASS_DEF = 64;

    localparam logic [4:0] CLS_LOG2 [NUM_CLASSES] =
        '{5'd4, 5'd5, 5'd6, 5'd8, 5'd10, 5'd12, 5'd13, 5'd15};
    localparam logic [DEPTH_W-1:0] CLS_COUNT [NUM_CLASSES] =
        '{7'd0, 7'd60, 7'd40, 7'd30, 7'd20, 7'd20, 7'd10, 7'd10};
    localparam logic [31:0] CLS_REGION [NUM_CLASSES] =
        '{32'h7FF80, 32'h7F800, 32'h7EE00, 32'h7D000,
          32'h78000, 32'h64000, 32'h50000, 32'h0};
    localparam logic [MARK_W-1:0] CLS_MARK_BASE [NUM_CLASSES] =
        '{8'd190, 8'd130, 8'd90, 8'd60, 8'd40, 8'd20, 8'd10, 8'd0};

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_BAD_FREE  = 3'd4;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_TOO_LARGE = 2'd2,
        CMD_BAD_FREE  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CLS_W-1:0]  cls;
        logic [BLK_W-1:0]  blk;
    } cmd_t;

endpackage

[rtl/scba_front.sv]
// ----------------------------------------------------------------------------
// scba_front
// Classifies a request: picks the class of an allocate, decodes a free address.
// ----------------------------------------------------------------------------
module scba_front
(
    input  logic                 action,
    input  logic [31:0]          request_size,
    input  logic [31:0]          block_address,
    input  logic [31:0]          pool_base,
    output scba_pkg::cmd_t       cmd
);

    logic [31:0]                   off;
    logic [31:0]                   rel;
    logic [31:0]                   span;
    logic [31:0]                   mask;
    logic                          hit;
    logic                          aligned;
    logic [scba_pkg::CLS_W-1:0]    hit_cls;
    logic [scba_pkg::BLK_W-1:0]    hit_blk;
    logic [scba_pkg::CLS_W-1:0]    pick;

    assign off = block_address - 32'd1 - pool_base;

    always_comb
    begin
        hit     = 1'b0;
        aligned = 1'b0;
        hit_cls = '0;
        hit_blk = '0;
        rel     = '0;
        span    = '0;
        mask    = '0;
        for (int c = 1; c < scba_pkg::NUM_CLASSES; c++)
        begin
            span = 32'(scba_pkg::CLS_COUNT[c]) << scba_pkg::CLS_LOG2[c];
            mask = (32'd1 << scba_pkg::CLS_LOG2[c]) - 32'd1;
            rel  = off - scba_pkg::CLS_REGION[c];
            if (off >= scba_pkg::CLS_REGION[c] && rel < span)
            begin
                hit     = 1'b1;
                aligned = ((rel & mask) == 32'd0);
                hit_cls = scba_pkg::CLS_W'(c);
                hit_blk = scba_pkg::BLK_W'(rel >> scba_pkg::CLS_LOG2[c]);
            end
        end
    end

    always_comb
    begin
        pick = '0;
        for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (request_size < (32'd1 << scba_pkg::CLS_LOG2[c]))
            begin
                pick = scba_pkg::CLS_W'(c);
            end
        end
    end

    always_comb
    begin
        cmd.cls = '0;
        cmd.blk = '0;
        if (!action)
        begin
            if (request_size >= 32'h8000)
            begin
                cmd.kind = scba_pkg::CMD_TOO_LARGE;
            end
            else
            begin
                cmd.kind = scba_pkg::CMD_ALLOC;
                cmd.cls  = pick;
            end
        end
        else if (hit && aligned)
        begin
            cmd.kind = scba_pkg::CMD_FREE;
            cmd.cls  = hit_cls;
            cmd.blk  = hit_blk;
        end
        else
        begin
            cmd.kind = scba_pkg::CMD_BAD_FREE;
        end
    end

endmodule

[rtl/scba_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// scba_cmd_fifo
// Two-entry command queue between classifier and stack engine.
// ----------------------------------------------------------------------------
module scba_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scba_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output scba_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);

    scba_pkg::cmd_t  entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/scba_back.sv]
// ----------------------------------------------------------------------------
// scba_back
// Stack engine: free stacks, depths, allocation marks and the result register.
// ----------------------------------------------------------------------------
module scba_back
#(
    parameter int MAX_PER_CLASS = scba_pkg::MAX_PER_CLASS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     pool_base,
    input  scba_pkg::cmd_t  head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     result_address,
    output logic [2:0]      status,
    output logic [2:0]      size_class
);

    localparam int PW = $clog2(MAX_PER_CLASS);
    localparam int AW = scba_pkg::CLS_W + PW;
    localparam int NC = scba_pkg::NUM_CLASSES;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [scba_pkg::DEPTH_W-1:0]    depth_reg [NC];
    logic [scba_pkg::DEPTH_W-1:0]    depth_next [NC];
    logic [scba_pkg::DEPTH_W-1:0]    low_reg [NC];
    logic [scba_pkg::DEPTH_W-1:0]    low_next [NC];
    logic [scba_pkg::TOTAL_BLOCKS-1:0] marks_reg, marks_next;
    logic [scba_pkg::CLS_W-1:0]      cls_reg, cls_next;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic                            fresh_reg, fresh_next;
    logic                            out_valid_reg, out_valid_next;
    logic [31:0]                     addr_reg, addr_next;
    logic [2:0]                      status_reg, status_next;
    logic [2:0]                      class_reg, class_next;

    logic [scba_pkg::BLK_W-1:0]      mem [2**AW];
    logic [scba_pkg::BLK_W-1:0]      rd_data_reg;
    logic                            mem_we, mem_re;
    logic [AW-1:0]                   mem_wa, mem_ra;
    logic [scba_pkg::BLK_W-1:0]      mem_wd;

    logic                            out_free;
    logic [scba_pkg::DEPTH_W-1:0]    d;
    logic [scba_pkg::DEPTH_W-1:0]    dm1;
    logic [scba_pkg::MARK_W-1:0]     mi;
    logic [scba_pkg::MARK_W-1:0]     ai;
    logic [scba_pkg::BLK_W-1:0]      blk;

    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign result_address = addr_reg;
    assign status         = status_reg;
    assign size_class     = class_reg;

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        low_next       = low_reg;
        marks_next     = marks_reg;
        cls_next       = cls_reg;
        pos_next       = pos_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && out_stall;
        addr_next      = addr_reg;
        status_next    = status_reg;
        class_next     = class_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wa         = {head.cls, PW'(depth_reg[head.cls])};
        mem_wd         = head.blk;
        d              = depth_reg[head.cls];
        dm1            = d - 7'd1;
        mem_ra         = {head.cls, PW'(dm1)};
        mi             = scba_pkg::CLS_MARK_BASE[head.cls] + scba_pkg::MARK_W'(head.blk);
        blk            = fresh_reg ? scba_pkg::BLK_W'(pos_reg) : rd_data_reg;
        ai             = scba_pkg::CLS_MARK_BASE[cls_reg] + scba_pkg::MARK_W'(blk);
        case (state_reg)
            S_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        scba_pkg::CMD_ALLOC:
                        begin
                            if (d == '0)
                            begin
                                out_valid_next = 1'b1;
                                addr_next      = '0;
                                status_next    = scba_pkg::ST_EMPTY;
                                class_next     = head.cls;
                            end
                            else
                            begin
                                depth_next[head.cls] = dm1;
                                fresh_next           = (dm1 < low_reg[head.cls]);
                                if (dm1 < low_reg[head.cls])
                                begin
                                    low_next[head.cls] = dm1;
                                end
                                cls_next   = head.cls;
                                pos_next   = PW'(dm1);
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        scba_pkg::CMD_FREE:
                        begin
                            out_valid_next = 1'b1;
                            addr_next      = '0;
                            if (marks_reg[mi] && d < scba_pkg::CLS_COUNT[head.cls])
                            begin
                                marks_next[mi]       = 1'b0;
                                mem_we               = 1'b1;
                                depth_next[head.cls] = d + 7'd1;
                                status_next          = scba_pkg::ST_FREED;
                                class_next           = head.cls;
                            end
                            else
                            begin
                                status_next = scba_pkg::ST_BAD_FREE;
                                class_next  = '0;
                            end
                        end
                        scba_pkg::CMD_TOO_LARGE:
                        begin
                            out_valid_next = 1'b1;
                            addr_next      = '0;
                            status_next    = scba_pkg::ST_TOO_LARGE;
                            class_next     = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            addr_next      = '0;
                            status_next    = scba_pkg::ST_BAD_FREE;
                            class_next     = '0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    marks_next[ai] = 1'b1;
                    out_valid_next = 1'b1;
                    addr_next      = pool_base + scba_pkg::CLS_REGION[cls_reg]
                                   + (32'(blk) << scba_pkg::CLS_LOG2[cls_reg]) + 32'd1;
                    status_next    = scba_pkg::ST_ALLOCATED;
                    class_next     = cls_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NC; c++)
            begin
                depth_reg[c] <= scba_pkg::CLS_COUNT[c];
                low_reg[c]   <= scba_pkg::CLS_COUNT[c];
            end
        end
        else
        begin
            state_reg     <= state_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
            low_reg       <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        pos_reg    <= pos_next;
        fresh_reg  <= fresh_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        class_reg  <= class_next;
    end

    // entries below the low mark were never written and read as their own position
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ && $past(state_reg) != S_READ |-> $past(pop))
        else $error("read state not entered by a queue pop");

    a_freed_has_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == scba_pkg::ST_FREED |-> class_reg != 3'd0)
        else $error("freed result without a class");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != scba_pkg::ST_ALLOCATED |-> addr_reg == 32'd0)
        else $error("non-allocate result carries an address");

    a_no_pop_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !pop)
        else $error("queue popped during a stack read");

endmodule

[rtl/size_class_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator_core
// Seven-class fixed pool allocator with per-class LIFO free stacks.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    action, request_size, block_address
//   out       out_valid / out_stall  result_address, status, size_class
//   cfg       cfg_wr_en              cfg_wr_data (pool_base)
//
// An allocate passes the queue write, a stack pop with a registered memory
// read, then the result register; a free or failed request passes the queue
// write, then the result register. The stack engine works on one command at
// a time; an allocate holds it for its stack read. Two queued commands let
// input continue while a result stalls. No clearing pass after reset.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core
#(
    parameter int MAX_PER_CLASS = scba_pkg::MAX_PER_CLASS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         action,
    input  logic [31:0]  request_size,
    input  logic [31:0]  block_address,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [31:0]  result_address,
    output logic [2:0]   status,
    output logic [2:0]   size_class
);

    logic [31:0]     pool_base_reg;
    scba_pkg::cmd_t  front_cmd;
    scba_pkg::cmd_t  head;
    logic            full;
    logic            empty;
    logic            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            pool_base_reg <= cfg_wr_data;
        end
    end

    assign in_stall = full;

    scba_front u_front
    (
        .action        (action),
        .request_size  (request_size),
        .block_address (block_address),
        .pool_base     (pool_base_reg),
        .cmd           (front_cmd)
    );

    scba_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !full),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    scba_back #(
        .MAX_PER_CLASS (MAX_PER_CLASS)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pool_base      (pool_base_reg),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .size_class     (size_class)
    );

endmodule
